// File: hdl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// shared constants, types and helpers of the chunked slot pool allocator
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int CHUNKS     = 16;
	localparam int MAX_SLOTS  = 1024;
	localparam int PAGE_SHIFT = 12;

	localparam int NCH        = 16;
	localparam int CID_W      = 4;
	localparam int ADDR_W     = 48;
	localparam int SLOT_IW    = $clog2(MAX_SLOTS);
	localparam int CNT_W      = SLOT_IW + 1;
	localparam int SCS_MAX    = $clog2(MAX_SLOTS + 1) - 1;
	localparam int LINK_AW    = CID_W + SLOT_IW;
	localparam int LINK_DEPTH = NCH * MAX_SLOTS;
	localparam int PW         = PAGE_SHIFT + 1;
	localparam int SUM_W      = ((CNT_W > PW) ? CNT_W : PW) + 1;
	localparam int SH_W       = 4;
	localparam int CSH_W      = 5;
	localparam int CCNT_W     = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [SH_W-1:0]   RST_SSZ    = 4'd4;
	localparam logic [SH_W-1:0]   RST_SCS    = 4'd10;
	localparam logic [CCNT_W-1:0] RST_CHUNKS = 5'd16;
	localparam logic [SH_W-1:0]   SSZ_MIN    = 4'd1;
	localparam logic [SH_W-1:0]   SSZ_MAX    = 4'd14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE   = 2'd0,
		REG_SSZ    = 2'd1,
		REG_SCS    = 2'd2,
		REG_CHUNKS = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef struct packed {
		logic accept;
		logic a_chk;
		logic thr;
		logic a_rd;
		logic a_ld;
		logic a_upd;
		logic f_chk;
		logic f_rng;
		logic f_upd;
		logic f_bub;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic a_fail;
		logic a_thr;
		logic thr_last;
		logic f_null;
		logic f_bad;
		logic bub_stop;
	} sts_t;

	function automatic logic [SH_W-1:0] eff_ssz(input logic [SH_W-1:0] r);
		logic [SH_W-1:0] v;
		v = r;
		if (r < SSZ_MIN) v = SSZ_MIN;
		if (r > SSZ_MAX) v = SSZ_MAX;
		return v;
	endfunction

	function automatic logic [SH_W-1:0] eff_scs(input logic [SH_W-1:0] r);
		return (r > SH_W'(SCS_MAX)) ? SH_W'(SCS_MAX) : r;
	endfunction

	function automatic logic [CCNT_W-1:0] eff_chunks(input logic [CCNT_W-1:0] r);
		return (r > CCNT_W'(CHUNKS)) ? CCNT_W'(CHUNKS) : r;
	endfunction

	function automatic logic [CNT_W-1:0] slot_cnt(input logic [SH_W-1:0] scs);
		return CNT_W'(1) << scs;
	endfunction

endpackage

// File: hdl/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl
// sequencer of the slot pool: steps one request through its datapath commands
// ----------------------------------------------------------------------------
module csp_ctrl import csp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_A_CHK = 11'b000_0000_0010,
		ST_A_THR = 11'b000_0000_0100,
		ST_A_RD  = 11'b000_0000_1000,
		ST_A_LD  = 11'b000_0001_0000,
		ST_A_UPD = 11'b000_0010_0000,
		ST_F_CHK = 11'b000_0100_0000,
		ST_F_RNG = 11'b000_1000_0000,
		ST_F_UPD = 11'b001_0000_0000,
		ST_F_BUB = 11'b010_0000_0000,
		ST_RES   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = (req_type == REQ_FREE) ? ST_F_CHK : ST_A_CHK;
				end
			end
			ST_A_CHK: begin
				cmd.a_chk = 1'b1;
				if (sts.a_fail) state_n = ST_RES;
				else if (sts.a_thr) state_n = ST_A_THR;
				else state_n = ST_A_RD;
			end
			ST_A_THR: begin
				cmd.thr = 1'b1;
				if (sts.thr_last) state_n = ST_A_UPD;
			end
			ST_A_RD: begin
				cmd.a_rd = 1'b1;
				state_n  = ST_A_LD;
			end
			ST_A_LD: begin
				cmd.a_ld = 1'b1;
				state_n  = ST_A_UPD;
			end
			ST_A_UPD: begin
				cmd.a_upd = 1'b1;
				state_n   = ST_RES;
			end
			ST_F_CHK: begin
				cmd.f_chk = 1'b1;
				state_n   = sts.f_null ? ST_RES : ST_F_RNG;
			end
			ST_F_RNG: begin
				cmd.f_rng = 1'b1;
				state_n   = sts.f_bad ? ST_RES : ST_F_UPD;
			end
			ST_F_UPD: begin
				cmd.f_upd = 1'b1;
				state_n   = ST_F_BUB;
			end
			ST_F_BUB: begin
				cmd.f_bub = 1'b1;
				if (sts.bub_stop) state_n = ST_RES;
			end
			ST_RES: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_upd_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_A_UPD |=> state_q == ST_RES)
		else $error("allocate update not followed by result stage");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_accept_branch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_A_CHK || state_q == ST_F_CHK))
		else $error("accepted request did not start");

endmodule

// File: hdl/csp_dpath.sv
// ----------------------------------------------------------------------------
// csp_dpath
// pool state, link memory, address arithmetic and result register
// ----------------------------------------------------------------------------
module csp_dpath import csp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic [ADDR_W-1:0]    free_addr,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 ok,
	output logic [ADDR_W-1:0]    slot_addr
);

	// configuration
	logic [ADDR_W-1:0] base_q, base_n;
	logic [SH_W-1:0]   ssz_raw_q, ssz_raw_n, scs_raw_q, scs_raw_n;
	logic [CCNT_W-1:0] chunks_raw_q, chunks_raw_n;
	logic [SH_W-1:0]   ssz, scs;
	logic [CSH_W-1:0]  csh;
	logic [CNT_W-1:0]  cnt, init_cnt;
	logic [CCNT_W-1:0] nch, init_nch;

	// pool state
	logic [CNT_W-1:0] head_q [NCH];
	logic [CNT_W-1:0] free_q [NCH];
	logic [CNT_W-1:0] mark_q [NCH];
	logic [CID_W-1:0] order_q[NCH];

	// working registers
	logic [ADDR_W-1:0] ptr_q;
	logic [CID_W-1:0]  c_q, pos_q;
	logic [CNT_W-1:0]  h_q, s_q, end_q, nh_q, fa_q;
	logic [ADDR_W:0]   off_q, lim_q;
	logic              res_ok_q, ok_q;
	logic [ADDR_W-1:0] res_addr_q, slot_addr_q;

	// link memory
	logic [CNT_W-1:0]   link_mem[LINK_DEPTH];
	logic [CNT_W-1:0]   rd_q;
	logic               mem_we;
	logic [LINK_AW-1:0] mem_wa, mem_ra;
	logic [CNT_W-1:0]   mem_wd;

	logic [CID_W-1:0]  cur_c, nb_c, fr_idx, fc, found;
	logic [CNT_W-1:0]  cur_head, cur_mark, fr, fnew, thr_end;
	logic [ADDR_W-1:0] alloc_addr, align_mask;
	logic [PW-1:0]     added;
	logic [SUM_W-1:0]  thr_sum;
	logic [SLOT_IW-1:0] fs;
	logic [CNT_W-1:0]  cnt_m1;
	logic              f_full;

	always_comb begin
		base_n       = base_q;
		ssz_raw_n    = ssz_raw_q;
		scs_raw_n    = scs_raw_q;
		chunks_raw_n = chunks_raw_q;
		unique case (cfg_reg_t'(cfg_index))
			REG_BASE:   base_n       = cfg_data;
			REG_SSZ:    ssz_raw_n    = cfg_data[SH_W-1:0];
			REG_SCS:    scs_raw_n    = cfg_data[SH_W-1:0];
			REG_CHUNKS: chunks_raw_n = cfg_data[CCNT_W-1:0];
			default: ;
		endcase
	end

	assign ssz      = eff_ssz(ssz_raw_q);
	assign scs      = eff_scs(scs_raw_q);
	assign csh      = {1'b0, ssz} + {1'b0, scs};
	assign cnt      = slot_cnt(scs);
	assign cnt_m1   = cnt - CNT_W'(1);
	assign nch      = eff_chunks(chunks_raw_q);
	assign init_cnt = slot_cnt(eff_scs(scs_raw_n));
	assign init_nch = eff_chunks(chunks_raw_n);

	assign cur_c    = cmd.a_chk ? order_q[0] : c_q;
	assign cur_head = head_q[cur_c];
	assign cur_mark = mark_q[cur_c];
	assign nb_c     = order_q[pos_q + CID_W'(1)];
	assign fr_idx   = cmd.f_bub ? nb_c : cur_c;
	assign fr       = free_q[fr_idx];

	// allocate: slot address and the end of the next run of lazy links
	assign alloc_addr = base_q + ((ADDR_W'(cur_c) << csh) | (ADDR_W'(cur_head) << ssz));
	assign added = (PAGE_SHIFT > 32'(ssz))
		? (PW'(1) << (CSH_W'(PAGE_SHIFT) - {1'b0, ssz})) : PW'(1);
	assign thr_sum = SUM_W'(cur_head) + SUM_W'(added);
	assign thr_end = (thr_sum > SUM_W'(cnt)) ? cnt : thr_sum[CNT_W-1:0];

	// free: chunk and slot from the offset
	assign align_mask = (ADDR_W'(1) << ssz) - ADDR_W'(1);
	assign fc   = CID_W'(off_q[ADDR_W-1:0] >> csh);
	assign fs   = SLOT_IW'(off_q[ADDR_W-1:0] >> ssz) & cnt_m1[SLOT_IW-1:0];
	assign fnew = (fr < cnt) ? fr + CNT_W'(1) : fr;
	assign f_full = (fnew == cnt);

	always_comb begin
		found = '0;
		for (int j = NCH - 1; j >= 0; j--) begin
			if (order_q[j] == c_q) found = CID_W'(j);
		end
	end

	assign sts.a_fail   = (fr == '0) || (cur_head >= cnt);
	assign sts.a_thr    = (cur_head >= cur_mark);
	assign sts.thr_last = ((s_q + CNT_W'(1)) == end_q);
	assign sts.f_null   = (ptr_q == '0);
	assign sts.f_bad    = off_q[ADDR_W] || ({1'b0, ptr_q} >= lim_q)
		|| ((ptr_q & align_mask) != '0);
	assign sts.bub_stop = (pos_q == CID_W'(NCH - 1)) || (fr == '0) || (fa_q <= fr);

	assign mem_we = cmd.thr || cmd.f_upd;
	assign mem_wa = {c_q, s_q[SLOT_IW-1:0]};
	assign mem_wd = cmd.thr ? s_q + CNT_W'(1) : cur_head;
	assign mem_ra = {c_q, h_q[SLOT_IW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.a_rd) rd_q <= link_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			ssz_raw_q    <= RST_SSZ;
			scs_raw_q    <= RST_SCS;
			chunks_raw_q <= RST_CHUNKS;
			for (int j = 0; j < NCH; j++) begin
				head_q[j]  <= '0;
				mark_q[j]  <= '0;
				free_q[j]  <= (CCNT_W'(j) < eff_chunks(RST_CHUNKS))
					? slot_cnt(eff_scs(RST_SCS)) : '0;
				order_q[j] <= CID_W'(j);
			end
		end else if (cfg_we) begin
			// any register write restarts the pool with the new shape
			base_q       <= base_n;
			ssz_raw_q    <= ssz_raw_n;
			scs_raw_q    <= scs_raw_n;
			chunks_raw_q <= chunks_raw_n;
			for (int j = 0; j < NCH; j++) begin
				head_q[j]  <= '0;
				mark_q[j]  <= '0;
				free_q[j]  <= (CCNT_W'(j) < init_nch) ? init_cnt : '0;
				order_q[j] <= CID_W'(j);
			end
		end else begin
			if (cmd.thr && sts.thr_last) mark_q[c_q] <= end_q;
			if (cmd.a_upd) begin
				head_q[c_q] <= nh_q;
				free_q[c_q] <= fr - CNT_W'(1);
				// emptied front chunk goes to the back
				if (fr == CNT_W'(1)) begin
					for (int j = 0; j < NCH - 1; j++) order_q[j] <= order_q[j+1];
					order_q[NCH-1] <= order_q[0];
				end
			end
			if (cmd.f_upd) begin
				free_q[c_q] <= fnew;
				head_q[c_q] <= f_full ? '0 : s_q;
				if (f_full) mark_q[c_q] <= '0;
			end
			if (cmd.f_bub && !sts.bub_stop) begin
				order_q[pos_q]              <= nb_c;
				order_q[pos_q + CID_W'(1)]  <= c_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) ptr_q <= free_addr;
		if (cmd.a_chk) begin
			c_q        <= order_q[0];
			h_q        <= cur_head;
			s_q        <= cur_head;
			end_q      <= thr_end;
			res_ok_q   <= !sts.a_fail;
			res_addr_q <= sts.a_fail ? '0 : alloc_addr;
		end
		if (cmd.thr) begin
			s_q <= s_q + CNT_W'(1);
			if (sts.thr_last) nh_q <= h_q + CNT_W'(1);
		end
		if (cmd.a_ld) nh_q <= rd_q;
		if (cmd.f_chk) begin
			off_q      <= {1'b0, ptr_q} - {1'b0, base_q};
			lim_q      <= {1'b0, base_q} + ((ADDR_W + 1)'(nch) << csh);
			res_ok_q   <= 1'b1;
			res_addr_q <= '0;
		end
		if (cmd.f_rng) begin
			c_q      <= fc;
			s_q      <= CNT_W'(fs);
			res_ok_q <= !sts.f_bad;
		end
		if (cmd.f_upd) begin
			fa_q  <= fnew;
			pos_q <= found;
		end
		if (cmd.f_bub && !sts.bub_stop) pos_q <= pos_q + CID_W'(1);
		if (cmd.res_load) begin
			ok_q        <= res_ok_q;
			slot_addr_q <= res_addr_q;
		end
	end

	assign ok        = ok_q;
	assign slot_addr = slot_addr_q;

	a_alloc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.a_upd |=> free_q[c_q] == $past(free_q[c_q]) - CNT_W'(1))
		else $error("allocate did not take one slot");

	a_thr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.thr |-> s_q < end_q)
		else $error("link run past its end");

	a_free_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.f_upd |=> (free_q[c_q] <= cnt) && (free_q[c_q] != '0))
		else $error("free count out of range after free");

endmodule

// File: hdl/chunked_slot_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// chunked_slot_pool_allocator_unit
// fixed-size slot allocator over up to sixteen chunks with lazy free lists
// ----------------------------------------------------------------------------
// One request at a time. An allocate whose head slot is already linked reads
// the link memory, loads the next head and updates the chunk. When the head
// reaches unlinked slots it writes links one by one (a page's worth of slots,
// up to the chunk's end), as the link memory has a single write port. A
// refused allocate goes straight to the result. A free checks the address and
// its range, updates the chunk and moves it back in the serve order one place
// per step (up to 15); a null address ends after the check and a rejected one
// after the range check. A new request is taken the cycle after the result is
// loaded, while that result may still wait at the output. A configuration
// write reinitialises the pool at once; the link memory needs no clearing.
module chunked_slot_pool_allocator_unit import csp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [ADDR_W-1:0]    free_addr,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic [ADDR_W-1:0]    slot_addr,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;

	csp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	csp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.free_addr (free_addr),
		.cmd       (cmd),
		.sts       (sts),
		.ok        (ok),
		.slot_addr (slot_addr)
	);

endmodule
